### rtl/core/cdq_pkg.sv
// Shared types and codes for the circular deque block.
// Holds the operation codes and the request and response word layouts.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package cdq_pkg;

  // Width of the capacity register.
  localparam int unsigned CAP_W = 11;
  // Width of one stored word.
  localparam int unsigned WORD_W = 32;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_QUERY      = 3'd4
  } cdq_mode_e;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [WORD_W-1:0] value;
  } cdq_in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } cdq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;  // apply the accepted request to indices, count and store
    logic rd;    // read the front and rear entries
    logic load;  // load the response register
  } cdq_cmd_t;

endpackage

### rtl/core/circular_deque_ring_buffer.sv
// Top level of the bounded double-ended queue held in a ring store.
// Depends on cdq_pkg, cdq_ctrl and cdq_dp.
`timescale 1ns / 1ps

// Each request word names one operation (push front, push back, pop front,
// pop back or query) and a value; each request yields exactly one response
// word with the success flag, the front and rear entries (all ones when the
// deque is empty) and the empty and full flags. A request passes through the
// steps of acceptance, whose closing edge updates the indices, the count and
// the store, the registered two-port read of the front and rear entries, and
// the load of the response register, after which the response is offered. The
// block takes no new request until the response register has been loaded; a
// response that is not taken holds the block in its last step until the
// response register frees up. The capacity register is written through
// cfg_we_i and cfg_data_i with no wait; a write empties the deque, a capacity
// of zero acts as one and a capacity above DEPTH acts as DEPTH. Write the
// capacity only while no request is in flight. The store itself is not
// cleared at reset, which is harmless because only entries written by a push
// are ever reported.
module circular_deque_ring_buffer
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cdq_in_t          in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cdq_out_t         out_o
);

  cdq_cmd_t cmd;

  // The controller sequences each request and owns the response handshake.
  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // The datapath keeps the store, indices, count, capacity and response word.
  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .out_o      (out_o)
  );

  // An accepted request is always followed by the store read in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.exec |=> cmd.rd)
    else $error("store read did not follow an accepted request");

  // An empty deque reports all ones for both the front and the rear entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.is_empty) |->
      (out_o.front_value == '1) && (out_o.rear_value == '1))
    else $error("empty deque reported a stored entry");

  // The capacity is never below one, so empty and full never show together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_o.is_empty && out_o.is_full))
    else $error("response reports both empty and full");

endmodule

### rtl/core/cdq_ctrl.sv
// Controller of the circular deque block: sequences accept, read and respond.
// Depends on cdq_pkg; drives the command struct of cdq_dp.
`timescale 1ns / 1ps

module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output cdq_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.exec = in_valid_i && (state_q == ST_IDLE);
    cmd_o.rd   = (state_q == ST_READ);
    cmd_o.load = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_RESP;
        end
        ST_RESP: begin
          if (cmd_o.load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/cdq_dp.sv
// Datapath of the circular deque block: ring store, indices, count, capacity.
// Depends on cdq_pkg; takes its commands from cdq_ctrl.
`timescale 1ns / 1ps

module cdq_dp
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  input  cdq_in_t          in_i,
  input  cdq_cmd_t         cmd_i,
  output cdq_out_t         out_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [CAP_W-1:0]  cap_q;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ok_q, ok_d;
  logic [WORD_W-1:0] front_rd_q, rear_rd_q;
  cdq_out_t          out_q;

  logic [CNT_W-1:0]  eff_cap;
  logic [IDX_W-1:0]  cap_m1;
  logic [IDX_W-1:0]  head_back, head_fwd, tail_back, tail_fwd;
  logic              full, empty;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;

  // Capacity in use: zero acts as one, anything above the store depth as the depth.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(CMP_W'(cap_q));
    end
  end

  assign cap_m1    = IDX_W'(eff_cap - CNT_W'(1));
  assign head_back = (head_q == '0) ? cap_m1 : head_q - IDX_W'(1);
  assign tail_back = (tail_q == '0) ? cap_m1 : tail_q - IDX_W'(1);
  assign head_fwd  = ((CNT_W'(head_q) + CNT_W'(1)) >= eff_cap) ? '0 : head_q + IDX_W'(1);
  assign tail_fwd  = ((CNT_W'(tail_q) + CNT_W'(1)) >= eff_cap) ? '0 : tail_q + IDX_W'(1);
  assign full      = (count_q >= eff_cap);
  assign empty     = (count_q == '0);

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    ok_d      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = tail_q;
    case (in_i.mode)
      MODE_PUSH_FRONT: begin
        if (!full) begin
          head_d    = head_back;
          mem_we    = 1'b1;
          mem_waddr = head_back;
          count_d   = count_q + CNT_W'(1);
          ok_d      = 1'b1;
        end
      end
      MODE_PUSH_BACK: begin
        if (!full) begin
          tail_d  = tail_fwd;
          mem_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
          ok_d    = 1'b1;
        end
      end
      MODE_POP_FRONT: begin
        if (!empty) begin
          head_d  = head_fwd;
          count_d = count_q - CNT_W'(1);
          ok_d    = 1'b1;
        end
      end
      MODE_POP_BACK: begin
        if (!empty) begin
          tail_d  = tail_back;
          count_d = count_q - CNT_W'(1);
          ok_d    = 1'b1;
        end
      end
      MODE_QUERY: begin
        ok_d = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_W'(1024);
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      ok_q    <= 1'b0;
    end else if (cfg_we_i) begin
      cap_q   <= cfg_data_i;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      ok_q    <= ok_d;
    end
  end

  // Store with one write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mem_we) begin
      mem[mem_waddr] <= in_i.value;
    end
    if (cmd_i.rd) begin
      front_rd_q <= mem[head_q];
      rear_rd_q  <= mem[tail_back];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.ok          <= ok_q;
      out_q.front_value <= empty ? '1 : front_rd_q;
      out_q.rear_value  <= empty ? '1 : rear_rd_q;
      out_q.is_empty    <= empty;
      out_q.is_full     <= full;
    end
  end

  assign out_o = out_q;

endmodule
